FILE: hw/rtl/ptc_pkg.sv
// shared constants, result type and crc byte update for the packet trailer check
`default_nettype none

package ptc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] PARITY_INIT = 16'h0000;
  localparam logic [1:0]  FILL_FULL  = 2'd3;
  localparam logic [1:0]  FILL_ABSORB = 2'd2;

  localparam logic MODE_CRC    = 1'b0;
  localparam logic MODE_PARITY = 1'b1;

  typedef struct packed {
    logic        check_ok;
    logic [15:0] computed_value;
    logic [15:0] received_value;
    logic        too_short;
  } ptc_result_t;

  // msb-first crc-16 over one byte, eight bit steps
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[15] ^ d[7]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ptc_core.sv
// check state: trailer delay line, crc register, parity word and result build
`default_nettype none

module ptc_core
  import ptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        check_mode,
  output ptc_result_t      result
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] parity_r, parity_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;
  logic [1:0]  fill_r, fill_nxt;

  always_comb begin
    crc_nxt    = crc_r;
    parity_nxt = parity_r;
    pend_nxt   = pend_r;
    phase_nxt  = phase_r;
    // oldest delayed byte enters the checks once two newer bytes sit behind it
    if (fill_r >= FILL_ABSORB) begin
      crc_nxt = crc16_byte(crc_r, dly0_r);
      if (!phase_r) begin
        pend_nxt  = dly0_r;
        phase_nxt = 1'b1;
      end else begin
        parity_nxt = parity_r ^ {pend_r, dly0_r};
        phase_nxt  = 1'b0;
      end
    end
    dly0_nxt = dly1_r;
    dly1_nxt = data_byte;
    fill_nxt = (fill_r == FILL_FULL) ? fill_r : fill_r + 2'd1;
  end

  always_comb begin
    result.computed_value = (check_mode == MODE_PARITY) ? parity_nxt : crc_nxt;
    result.received_value = {dly0_nxt, dly1_nxt};
    result.too_short      = (fill_nxt != FILL_FULL);
    result.check_ok       = !result.too_short &&
                            (result.computed_value == result.received_value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      parity_r <= PARITY_INIT;
      pend_r   <= '0;
      phase_r  <= 1'b0;
      dly0_r   <= '0;
      dly1_r   <= '0;
      fill_r   <= '0;
    end else if (step) begin
      if (last_byte) begin
        // packet done, start the next one clean
        crc_r    <= CRC_INIT;
        parity_r <= PARITY_INIT;
        pend_r   <= '0;
        phase_r  <= 1'b0;
        dly0_r   <= '0;
        dly1_r   <= '0;
        fill_r   <= '0;
      end else begin
        crc_r    <= crc_nxt;
        parity_r <= parity_nxt;
        pend_r   <= pend_nxt;
        phase_r  <= phase_nxt;
        dly0_r   <= dly0_nxt;
        dly1_r   <= dly1_nxt;
        fill_r   <= fill_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> fill_r == 2'd0 && crc_r == CRC_INIT && !phase_r)
    else $error("state not cleared after last byte");

  a_parity_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_byte && fill_r < FILL_ABSORB |=> phase_r == $past(phase_r))
    else $error("parity phase moved before any byte was absorbed");

endmodule

`default_nettype wire

FILE: hw/rtl/packet_trailer_check.sv
// Packet trailer check, top level. Bytes of one packet arrive on the in_
// channel, the final byte flagged by in_last_byte; the last two bytes are the
// trailer and are held back from the check by a two-byte delay line. One
// transaction is taken every clock cycle while in_stall is low. A byte is
// registered in the input register, the byte-wide crc and parity network then
// updates the check state and, for a last byte, loads the result register,
// which then offers the result on out_valid.
// cfg_check_mode selects crc-16 ccitt (0) or 16-bit vertical parity (1); write
// it only while the block is idle.
// One result is delivered per packet; packets under three bytes report
// too_short with check_ok low.
`default_nettype none

module packet_trailer_check
  import ptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_check_ok,
  output logic [15:0]      out_computed_value,
  output logic [15:0]      out_received_value,
  output logic             out_too_short,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_check_mode
);

  logic        mode_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  ptc_result_t out_res_r;
  ptc_result_t core_res;
  logic        advance;
  logic        step;

  // stage one moves when the result register is free or being emptied
  assign advance   = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CRC;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_check_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  ptc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .check_mode (mode_r),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_check_ok       = out_res_r.check_ok;
  assign out_computed_value = out_res_r.computed_value;
  assign out_received_value = out_res_r.received_value;
  assign out_too_short      = out_res_r.too_short;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_last_r |=> out_valid_r)
    else $error("last byte processed but no result offered");

  a_short_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.too_short |-> !out_res_r.check_ok)
    else $error("short packet reported as passing");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    step && !s1_last_r && !(out_valid_r && out_stall) |=> !out_valid_r)
    else $error("result produced for a byte without last mark");

endmodule

`default_nettype wire

FILE: tb/ptc_checker.sv
// channel monitor, trailer check predictor and result comparison for packet_trailer_check
`timescale 1ns / 1ps

package ptc_tb_pkg;

  import ptc_pkg::*;

  // msb-first ccitt update: fold the byte into the top half, then shift out eight bits
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

module ptc_checker
  import ptc_pkg::*;
  import ptc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_check_ok,
  input  logic [15:0] out_computed_value,
  input  logic [15:0] out_received_value,
  input  logic        out_too_short,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_check_mode,
  output int          fail_count,
  output int          verdicts_waiting
);

  logic        mode_q;
  logic [15:0] crc_q;
  logic [15:0] par_q;
  logic [7:0]  hi_q;
  logic        phase_q;
  logic [7:0]  tail_q [2];
  logic [1:0]  seen_q;

  ptc_result_t verdicts_due [$];

  task automatic clear_packet();
    crc_q     = CRC_INIT;
    par_q     = PARITY_INIT;
    hi_q      = 8'h00;
    phase_q   = 1'b0;
    tail_q[0] = 8'h00;
    tail_q[1] = 8'h00;
    seen_q    = 2'd0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    ptc_result_t r;
    // the oldest byte leaves the trailer window and enters both checks
    if (seen_q >= FILL_ABSORB) begin
      crc_q = crc16_update(crc_q, tail_q[0]);
      if (!phase_q) begin
        hi_q    = tail_q[0];
        phase_q = 1'b1;
      end else begin
        par_q   = par_q ^ {hi_q, tail_q[0]};
        phase_q = 1'b0;
      end
    end
    tail_q[0] = tail_q[1];
    tail_q[1] = b;
    if (seen_q != FILL_FULL) seen_q = seen_q + 2'd1;
    if (last) begin
      r.too_short      = (seen_q != FILL_FULL);
      r.computed_value = (mode_q == MODE_PARITY) ? par_q : crc_q;
      r.received_value = {tail_q[0], tail_q[1]};
      r.check_ok       = !r.too_short && (r.computed_value == r.received_value);
      verdicts_due.push_back(r);
      clear_packet();
    end
  endtask

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ptc_result_t want;
    if (!rst_n) begin
      mode_q = MODE_CRC;
      clear_packet();
      verdicts_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_q = cfg_check_mode;
      if (in_valid && !in_stall) take_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result transaction with none expected (computed %h, received %h)",
                   $time, out_computed_value, out_received_value);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          compare_field("check_ok", 16'(want.check_ok), 16'(out_check_ok));
          compare_field("computed_value", want.computed_value, out_computed_value);
          compare_field("received_value", want.received_value, out_received_value);
          compare_field("too_short", 16'(want.too_short), 16'(out_too_short));
        end
      end
    end
    verdicts_waiting <= verdicts_due.size();
  end

endmodule

FILE: tb/tb_top.sv
// top of the packet_trailer_check testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb_top;

  import ptc_pkg::*;
  import ptc_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 150;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_check_ok;
  logic [15:0] out_computed_value;
  logic [15:0] out_received_value;
  logic        out_too_short;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_check_mode;

  int fail_count;
  int verdicts_waiting;
  int hold_asks = 0;
  bit calm = 1'b0;
  logic cur_mode = MODE_CRC;
  logic [7:0] frame [$];
  int idle_cycles = 0;

  packet_trailer_check dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_check_ok       (out_check_ok),
    .out_computed_value (out_computed_value),
    .out_received_value (out_received_value),
    .out_too_short      (out_too_short),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_check_mode     (cfg_check_mode)
  );

  ptc_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_check_ok       (out_check_ok),
    .out_computed_value (out_computed_value),
    .out_received_value (out_received_value),
    .out_too_short      (out_too_short),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_check_mode     (cfg_check_mode),
    .fail_count         (fail_count),
    .verdicts_waiting   (verdicts_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles in a row without any transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver: random stalls, plus one long hold-off per request
  initial begin
    int served;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_asks) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 22);
      end
    end
  end

  // random idle gaps before about one byte in nine, unless calm is set
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame();
    foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
  endtask

  // word the block should compute over the current frame body
  function automatic logic [15:0] trailer_word(input logic m);
    logic [15:0] crc;
    logic [15:0] par;
    crc = CRC_INIT;
    par = PARITY_INIT;
    foreach (frame[i]) begin
      crc = crc16_update(crc, frame[i]);
      if (i % 2 == 1) par = par ^ {frame[i-1], frame[i]};
    end
    return (m == MODE_PARITY) ? par : crc;
  endfunction

  task automatic add_trailer(input logic m, input logic [15:0] flip);
    logic [15:0] w;
    w = trailer_word(m) ^ flip;
    frame.push_back(w[15:8]);
    frame.push_back(w[7:0]);
  endtask

  task automatic make_random_frame();
    int pick;
    int body_len;
    frame.delete();
    pick = $urandom_range(99);
    if (pick < 8) body_len = $urandom_range(1, 2);
    else if (pick < 92) body_len = $urandom_range(1, 14);
    else body_len = $urandom_range(15, 40);
    repeat (body_len) begin
      if ($urandom_range(9) == 0) frame.push_back($urandom_range(1) ? 8'hFF : 8'h00);
      else frame.push_back(8'($urandom()));
    end
    // short packets go out bare, the rest mostly carry a good trailer
    if (pick >= 8) begin
      if ($urandom_range(99) < 75) add_trailer(cur_mode, 16'h0000);
      else add_trailer(cur_mode, 16'($urandom_range(1, 16'hFFFF)));
    end
  endtask

  // wait out every expected result plus the pipeline latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_valid      <= 1'b1;
    cfg_check_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    int sent;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_last_byte   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_check_mode = MODE_CRC;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short packets, minimal packet, good crc over extreme bytes
    frame = '{8'hFF};
    send_frame();
    frame = '{8'h00, 8'hA5};
    send_frame();
    frame = '{8'h80, 8'h12, 8'h34};
    send_frame();
    frame = '{8'h00, 8'hFF, 8'h7F};
    add_trailer(MODE_CRC, 16'h0000);
    send_frame();

    // parity with an odd leftover byte
    write_mode(MODE_PARITY);
    frame = '{8'hAB, 8'hCD, 8'hEF};
    add_trailer(MODE_PARITY, 16'h0000);
    send_frame();

    // mode switched halfway through a packet
    push_byte(8'h55, 1'b0);
    push_byte(8'h01, 1'b0);
    write_mode(MODE_CRC);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0] ? MODE_PARITY : MODE_CRC);
      calm = (ph == 2);
      if (ph == 3) hold_asks++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        make_random_frame();
        send_frame();
        sent += frame.size();
      end
    end

    calm = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_core.sv
hw/rtl/packet_trailer_check.sv
tb/ptc_checker.sv
tb/tb_top.sv
